/* src/multidim_array_offset_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the array offset generator checker.
// Both macros sample on the rising edge of i_clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTIDIM_ARRAY_OFFSET_TOP_DEFINES_SVH
`define MULTIDIM_ARRAY_OFFSET_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mao_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mao_pkg
// Shared widths, reset values, register codes and interface types of the
// multi-dimensional array offset generator.
// ----------------------------------------------------------------------------
package mao_pkg;

    // Number of index lanes; one per size register and index field.
    localparam int NUM_LANES  = 4;

    // Field widths.
    localparam int IDX_W      = 16;
    localparam int SIZE_W     = 10;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int OFF_W      = 44;
    localparam int BAD_W      = 3;

    // Internal arithmetic widths. An extent is at most 1024, so the running
    // products of extents need 21 and 31 bits, and an in-bounds index fits
    // in the size width.
    localparam int EXT_W      = SIZE_W + 1;
    localparam int P01_W      = 21;
    localparam int STRIDE_W   = 31;
    localparam int TERM_W     = SIZE_W + STRIDE_W;
    localparam int SUM_W      = TERM_W + 2;

    // Reset values: a one-dimensional array of declared size ten.
    localparam logic [CNT_W-1:0]  RESET_DIM_COUNT  = 3'd1;
    localparam logic [SIZE_W-1:0] AUTO_DIM_SIZE    = 10'd10;
    localparam logic [SIZE_W-1:0] DEFAULT_DIM_SIZE = 10'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_COUNT = 3'd0,
        CFG_SIZE_DIM0 = 3'd1,
        CFG_SIZE_DIM1 = 3'd2,
        CFG_SIZE_DIM2 = 3'd3,
        CFG_SIZE_DIM3 = 3'd4
    } t_cfg_reg;

    typedef logic [SIZE_W-1:0] t_size;

    // Per-lane control from the top level.
    typedef struct packed {
        logic advance;
        logic used;
    } t_lane_ctl;

    // One result word.
    typedef struct packed {
        logic [OFF_W-1:0] byte_offset;
        logic             out_of_bounds;
        logic [BAD_W-1:0] bad_dimension;
        t_size            highest_allowed;
    } t_result;

endpackage

/* src/mao_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mao_lane
// One index lane: checks its index against the dimension's extent, then
// multiplies the index by the dimension's stride.
// ----------------------------------------------------------------------------
module mao_lane (
    input  logic                          i_clk,
    input  mao_pkg::t_lane_ctl            i_ctl,
    input  logic [mao_pkg::IDX_W-1:0]     i_index,
    input  mao_pkg::t_size                i_size,
    input  logic [mao_pkg::STRIDE_W-1:0]  i_stride,
    output logic                          o_oob,
    output logic [mao_pkg::TERM_W-1:0]    o_term
);

    logic                         r_oob;
    logic [mao_pkg::SIZE_W-1:0]   r_idx;
    logic [mao_pkg::TERM_W-1:0]   r_term;
    logic [mao_pkg::TERM_W-1:0]   product;

    // First stage: an index above the declared size lies outside the extent.
    // An unused lane contributes a zero index and never fails.
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_oob <= i_ctl.used && (i_index > mao_pkg::IDX_W'(i_size));
            r_idx <= i_ctl.used ? i_index[mao_pkg::SIZE_W-1:0] : '0;
        end
    end

    // Second stage: weighted term of this dimension.
    assign product = mao_pkg::TERM_W'(r_idx) * mao_pkg::TERM_W'(i_stride);

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_term <= product;
        end
    end

    assign o_oob  = r_oob;
    assign o_term = r_term;

endmodule

/* src/mao_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mao_merge
// Combines the lanes: picks the first failing dimension, sums the weighted
// terms, scales by the element size and adds the header.
// ----------------------------------------------------------------------------
module mao_merge #(
    parameter int ELEM_BYTES        = 8,
    parameter int HEADER_WORD_BYTES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_advance,
    input  logic [mao_pkg::NUM_LANES-1:0]    i_oob,
    input  mao_pkg::t_size                   i_size [mao_pkg::NUM_LANES],
    input  logic [mao_pkg::TERM_W-1:0]       i_term [mao_pkg::NUM_LANES],
    input  logic [mao_pkg::CNT_W-1:0]        i_eff_cnt,
    output mao_pkg::t_result                 o_result
);

    localparam int EB_W   = $clog2(ELEM_BYTES + 1);
    localparam int WIDE_W = mao_pkg::SUM_W + EB_W;

    logic                          found;
    logic [mao_pkg::BAD_W-1:0]     n_bad;
    mao_pkg::t_size                n_high;
    logic [mao_pkg::SUM_W-1:0]     n_sum;
    logic [WIDE_W-1:0]             scaled;
    logic [WIDE_W-1:0]             header;
    logic [WIDE_W:0]               full_offset;

    logic                          r_oob2;
    logic [mao_pkg::BAD_W-1:0]     r_bad2;
    mao_pkg::t_size                r_high2;
    logic                          r_oob3;
    logic [mao_pkg::BAD_W-1:0]     r_bad3;
    mao_pkg::t_size                r_high3;
    logic [mao_pkg::SUM_W-1:0]     r_sum;
    mao_pkg::t_result              r_result;

    // The lowest failing dimension wins.
    always_comb begin
        found  = 1'b0;
        n_bad  = '0;
        n_high = '0;
        for (int k = 0; k < mao_pkg::NUM_LANES; k++) begin
            if (i_oob[k] && !found) begin
                found  = 1'b1;
                n_bad  = mao_pkg::BAD_W'(k + 1);
                n_high = i_size[k];
            end
        end
    end

    // Sum of the weighted terms of all lanes.
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < mao_pkg::NUM_LANES; k++) begin
            n_sum = n_sum + mao_pkg::SUM_W'(i_term[k]);
        end
    end

    // Scale by the element size (a small constant) and add one header word
    // per dimension; the offset keeps its low bits.
    assign scaled      = WIDE_W'(r_sum) * WIDE_W'(ELEM_BYTES);
    assign header      = WIDE_W'(i_eff_cnt) * WIDE_W'(HEADER_WORD_BYTES);
    assign full_offset = (WIDE_W + 1)'(scaled) + (WIDE_W + 1)'(header);

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            // Bounds verdict, aligned with the lane terms.
            r_oob2  <= found;
            r_bad2  <= n_bad;
            r_high2 <= n_high;
            // Term sum.
            r_oob3  <= r_oob2;
            r_bad3  <= r_bad2;
            r_high3 <= r_high2;
            r_sum   <= n_sum;
            // Output word.
            r_result.byte_offset     <= r_oob3 ? '0 : full_offset[mao_pkg::OFF_W-1:0];
            r_result.out_of_bounds   <= r_oob3;
            r_result.bad_dimension   <= r_bad3;
            r_result.highest_allowed <= r_high3;
        end
    end

    assign o_result = r_result;

endmodule

/* src/multidim_array_offset_top.sv */
`timescale 1ns / 1ps
// Each index word passes the input register, both lane stages, the term sum and the output word.
// Throughput: one word per cycle unless the output stalls; the four lanes and merge are pipelined.
// Strides follow a configuration write via r_p01 and r_p012, ahead of any word that uses them.
// Reset (synchronous, active low) empties the pipeline and restores a 1-D array of size 10.
// The input is stalled and configuration is refused while reset is held.
// ----------------------------------------------------------------------------
// multidim_array_offset_top
// Byte offset generator for an element of a multi-dimensional array block,
// with a bounds check on every used index.
// ----------------------------------------------------------------------------
module multidim_array_offset_top #(
    parameter int MAX_DIMS          = 4,
    parameter int ELEM_BYTES        = 8,
    parameter int HEADER_WORD_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mao_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mao_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Index words.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mao_pkg::IDX_W-1:0]           i_index_dim0,
    input  logic [mao_pkg::IDX_W-1:0]           i_index_dim1,
    input  logic [mao_pkg::IDX_W-1:0]           i_index_dim2,
    input  logic [mao_pkg::IDX_W-1:0]           i_index_dim3,
    // Result words.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mao_pkg::OFF_W-1:0]           o_byte_offset,
    output logic                                o_out_of_bounds,
    output logic [mao_pkg::BAD_W-1:0]           o_bad_dimension,
    output logic [mao_pkg::SIZE_W-1:0]          o_highest_allowed
);

    localparam int CAP = (MAX_DIMS < mao_pkg::NUM_LANES) ? MAX_DIMS : mao_pkg::NUM_LANES;

    logic [mao_pkg::CNT_W-1:0]      r_dim_count;
    mao_pkg::t_size                 r_size [mao_pkg::NUM_LANES];
    logic [mao_pkg::CNT_W-1:0]      n_eff_cnt;
    logic [mao_pkg::CNT_W-1:0]      r_eff_cnt;

    logic [mao_pkg::EXT_W-1:0]      ext0;
    logic [mao_pkg::EXT_W-1:0]      ext1;
    logic [mao_pkg::EXT_W-1:0]      ext2;
    logic [mao_pkg::P01_W-1:0]      prod01;
    logic [mao_pkg::STRIDE_W-1:0]   prod012;
    logic [mao_pkg::P01_W-1:0]      r_p01;
    logic [mao_pkg::STRIDE_W-1:0]   r_p012;
    logic [mao_pkg::STRIDE_W-1:0]   stride [mao_pkg::NUM_LANES];

    logic                           advance;
    logic                           r_v0;
    logic                           r_v1;
    logic                           r_v2;
    logic                           r_v3;
    logic                           r_out_valid;
    logic [mao_pkg::IDX_W-1:0]      r_s0_idx [mao_pkg::NUM_LANES];

    logic [mao_pkg::NUM_LANES-1:0]  lane_oob;
    logic [mao_pkg::TERM_W-1:0]     lane_term [mao_pkg::NUM_LANES];
    mao_pkg::t_result               result;

    // Configuration registers; writes to unknown indexes are dropped.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= mao_pkg::RESET_DIM_COUNT;
            r_size[0]   <= mao_pkg::AUTO_DIM_SIZE;
            r_size[1]   <= mao_pkg::DEFAULT_DIM_SIZE;
            r_size[2]   <= mao_pkg::DEFAULT_DIM_SIZE;
            r_size[3]   <= mao_pkg::DEFAULT_DIM_SIZE;
        end else if (i_cfg_valid) begin
            unique case (mao_pkg::t_cfg_reg'(i_cfg_index))
                mao_pkg::CFG_DIM_COUNT: begin
                    r_dim_count <= i_cfg_data[mao_pkg::CNT_W-1:0];
                end
                mao_pkg::CFG_SIZE_DIM0: begin
                    r_size[0] <= i_cfg_data;
                end
                mao_pkg::CFG_SIZE_DIM1: begin
                    r_size[1] <= i_cfg_data;
                end
                mao_pkg::CFG_SIZE_DIM2: begin
                    r_size[2] <= i_cfg_data;
                end
                mao_pkg::CFG_SIZE_DIM3: begin
                    r_size[3] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Effective dimension count: at least one, at most the lane count.
    always_comb begin
        priority if (r_dim_count == '0) begin
            n_eff_cnt = mao_pkg::CNT_W'(1);
        end else if (r_dim_count > mao_pkg::CNT_W'(CAP)) begin
            n_eff_cnt = mao_pkg::CNT_W'(CAP);
        end else begin
            n_eff_cnt = r_dim_count;
        end
    end

    // Strides are products of the earlier extents, with one multiply before each product register.
    // An extent is at most 1024, so both products fit their widths.
    assign ext0    = mao_pkg::EXT_W'(r_size[0]) + mao_pkg::EXT_W'(1);
    assign ext1    = mao_pkg::EXT_W'(r_size[1]) + mao_pkg::EXT_W'(1);
    assign ext2    = mao_pkg::EXT_W'(r_size[2]) + mao_pkg::EXT_W'(1);
    assign prod01  = mao_pkg::P01_W'(ext0) * mao_pkg::P01_W'(ext1);
    assign prod012 = mao_pkg::STRIDE_W'(r_p01) * mao_pkg::STRIDE_W'(ext2);

    always_ff @(posedge i_clk) begin
        r_eff_cnt <= n_eff_cnt;
        r_p01     <= prod01;
        r_p012    <= prod012;
    end

    assign stride[0] = mao_pkg::STRIDE_W'(1);
    assign stride[1] = mao_pkg::STRIDE_W'(ext0);
    assign stride[2] = mao_pkg::STRIDE_W'(r_p01);
    assign stride[3] = r_p012;

    // The whole pipeline moves unless a finished word is held at the output.
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !i_rst_n || !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_v0        <= i_in_valid;
            r_v1        <= r_v0;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s0_idx[0] <= i_index_dim0;
            r_s0_idx[1] <= i_index_dim1;
            r_s0_idx[2] <= i_index_dim2;
            r_s0_idx[3] <= i_index_dim3;
        end
    end

    // One lane per dimension.
    for (genvar g = 0; g < mao_pkg::NUM_LANES; g++) begin : g_lane
        localparam logic [mao_pkg::CNT_W-1:0] LANE_NUM = mao_pkg::CNT_W'(g);
        mao_pkg::t_lane_ctl ctl;

        assign ctl.advance = advance;
        assign ctl.used    = LANE_NUM < r_eff_cnt;

        mao_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_index  (r_s0_idx[g]),
            .i_size   (r_size[g]),
            .i_stride (stride[g]),
            .o_oob    (lane_oob[g]),
            .o_term   (lane_term[g])
        );
    end

    // Merge of the lane results into one output word.
    mao_merge #(
        .ELEM_BYTES        (ELEM_BYTES),
        .HEADER_WORD_BYTES (HEADER_WORD_BYTES)
    ) u_merge (
        .i_clk     (i_clk),
        .i_advance (advance),
        .i_oob     (lane_oob),
        .i_size    (r_size),
        .i_term    (lane_term),
        .i_eff_cnt (r_eff_cnt),
        .o_result  (result)
    );

    assign o_out_valid       = r_out_valid;
    assign o_byte_offset     = result.byte_offset;
    assign o_out_of_bounds   = result.out_of_bounds;
    assign o_bad_dimension   = result.bad_dimension;
    assign o_highest_allowed = result.highest_allowed;

endmodule

/* src/mao_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mao_checker
// Port-level checks of the array offset generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "multidim_array_offset_top_defines.svh"

module mao_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [mao_pkg::OFF_W-1:0]           o_byte_offset,
    input  logic                                o_out_of_bounds,
    input  logic [mao_pkg::BAD_W-1:0]           o_bad_dimension,
    input  logic [mao_pkg::SIZE_W-1:0]          o_highest_allowed
);

    logic out_held;
    logic in_bounds_res;
    logic oob_res;
    logic err_clear;
    logic oob_sane;
    logic [mao_pkg::OFF_W+mao_pkg::BAD_W+mao_pkg::SIZE_W:0] out_word;

    // Views of the result channel used by the checks below.
    assign out_held      = o_out_valid && i_out_stall;
    assign in_bounds_res = o_out_valid && !o_out_of_bounds;
    assign oob_res       = o_out_valid && o_out_of_bounds;
    assign err_clear     = (o_bad_dimension == '0) && (o_highest_allowed == '0);
    assign oob_sane      = (o_byte_offset == '0) && (o_bad_dimension != '0)
                           && (o_bad_dimension <= mao_pkg::BAD_W'(mao_pkg::NUM_LANES));
    assign out_word      = {o_byte_offset, o_out_of_bounds, o_bad_dimension,
                            o_highest_allowed};

    // A held result word keeps its contents.
    `MAO_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(out_word), "held word changed")

    // The input is only stalled when a result word is blocked.
    `MAO_ASSERT_NOW(a_in_stall_cause, !out_held, !o_in_stall, "stall without backpressure")

    // An in-bounds result reports no failing dimension.
    `MAO_ASSERT_NOW(a_in_bounds_clean, in_bounds_res, err_clear, "error fields set")

    // An out-of-bounds result has a zero offset and names a real dimension.
    `MAO_ASSERT_NOW(a_oob_report, oob_res, oob_sane, "bad out-of-bounds report")

endmodule

bind multidim_array_offset_top mao_checker u_mao_checker (.*);

/* tb/tb_multidim_array_offset_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multidim_array_offset_top
// Self-checking bench for the array offset generator. A short table of
// directed accesses covers the reset shape, size-zero and full-size dimensions
// and the dimension count limits. Random shapes with mostly in-bounds indices
// follow. Every result word is compared field by field with a typed result or a local model,
// while both handshakes idle at random and the output is held off once.
// ----------------------------------------------------------------------------
module tb_multidim_array_offset_top;
    import mao_pkg::*;

    localparam int MAX_DIMS          = 4;
    localparam int ELEM_BYTES        = 8;
    localparam int HEADER_WORD_BYTES = 8;

    localparam int IDLE_PCT       = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 14;
    localparam int PHASE_WORDS    = 110;
    localparam int QUIET_PHASE    = 1;
    localparam int HOLD_PHASE     = 3;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 10;

    // Register indexes past the last size register; writes there are dropped.
    localparam int FIRST_SPARE_REG = int'(CFG_SIZE_DIM3) + 1;
    localparam int LAST_SPARE_REG  = (1 << CFG_IDX_W) - 1;

    // Index lanes of one access; lane 0 is the fastest-varying dimension.
    typedef logic [NUM_LANES-1:0][IDX_W-1:0]  idx_word_t;
    typedef logic [NUM_LANES-1:0][SIZE_W-1:0] size_set_t;

    typedef struct packed {
        idx_word_t idx;
        t_result   res;
    } access_t;

    // One directed access: the array shape it runs under, the indices and,
    // where it is obvious, the result typed in by hand.
    typedef struct packed {
        logic [CNT_W-1:0] dims;
        size_set_t        sizes;
        idx_word_t        idx;
        logic             known;
        t_result          res;
    } probe_row_t;

    localparam size_set_t RST_SIZES  = {10'd1, 10'd1, 10'd1, 10'd10};
    localparam size_set_t FULL_SIZES = {10'd1023, 10'd1023, 10'd1023, 10'd1023};
    localparam size_set_t ZERO_SIZES = '0;
    localparam size_set_t MIX_SIZES  = {10'd3, 10'd0, 10'd5, 10'd2};
    localparam size_set_t TWO_SIZES  = {10'd1023, 10'd1023, 10'd7, 10'd1023};
    localparam size_set_t TRI_SIZES  = {10'd1, 10'd1023, 10'd1, 10'd1};

    localparam int NUM_PROBES = 21;

    // Indices are written dimension 3 first, dimension 0 last.
    probe_row_t probe_rows [NUM_PROBES] = '{
        // Reset shape: one dimension of declared size ten.
        '{3'd1, RST_SIZES, {16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, '{44'd8, 1'b0, 3'd0, 10'd0}},
        '{3'd1, RST_SIZES, {16'd0, 16'd0, 16'd0, 16'd10},
          1'b1, '{44'd88, 1'b0, 3'd0, 10'd0}},
        '{3'd1, RST_SIZES, {16'd0, 16'd0, 16'd0, 16'd11},
          1'b1, '{44'd0, 1'b1, 3'd1, 10'd10}},
        '{3'd1, RST_SIZES, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3},
          1'b1, '{44'd32, 1'b0, 3'd0, 10'd0}},
        '{3'd1, RST_SIZES, {16'd0, 16'd0, 16'd0, 16'hFFFF},
          1'b1, '{44'd0, 1'b1, 3'd1, 10'd10}},
        // Four dimensions at the largest declared size.
        '{3'd4, FULL_SIZES, {16'd1023, 16'd1023, 16'd1023, 16'd1023},
          1'b0, '0},
        '{3'd4, FULL_SIZES, {16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, '{44'd32, 1'b0, 3'd0, 10'd0}},
        '{3'd4, FULL_SIZES, {16'd1023, 16'd1023, 16'd1023, 16'd1024},
          1'b1, '{44'd0, 1'b1, 3'd1, 10'd1023}},
        '{3'd4, FULL_SIZES, {16'd1024, 16'd0, 16'd0, 16'd0},
          1'b1, '{44'd0, 1'b1, 3'd4, 10'd1023}},
        '{3'd4, FULL_SIZES, {16'hFFFF, 16'hFFFF, 16'd0, 16'd0},
          1'b1, '{44'd0, 1'b1, 3'd3, 10'd1023}},
        // A count of zero acts as one; a size of zero allows only index 0.
        '{3'd0, ZERO_SIZES, {16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, '{44'd8, 1'b0, 3'd0, 10'd0}},
        '{3'd0, ZERO_SIZES, {16'd0, 16'd0, 16'd0, 16'd1},
          1'b1, '{44'd0, 1'b1, 3'd1, 10'd0}},
        '{3'd0, ZERO_SIZES, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0},
          1'b1, '{44'd8, 1'b0, 3'd0, 10'd0}},
        // A count above the limit saturates to four dimensions.
        '{3'd7, MIX_SIZES, {16'd3, 16'd0, 16'd5, 16'd2},
          1'b0, '0},
        '{3'd7, MIX_SIZES, {16'd0, 16'd1, 16'd0, 16'd0},
          1'b1, '{44'd0, 1'b1, 3'd3, 10'd0}},
        '{3'd7, MIX_SIZES, {16'd4, 16'd0, 16'd0, 16'd0},
          1'b1, '{44'd0, 1'b1, 3'd4, 10'd3}},
        '{3'd7, MIX_SIZES, {16'd1, 16'd0, 16'd2, 16'd1},
          1'b0, '0},
        // Two and three dimensions, some with the spare lanes driven high.
        '{3'd2, TWO_SIZES, {16'hFFFF, 16'hFFFF, 16'd7, 16'd1023},
          1'b0, '0},
        '{3'd2, TWO_SIZES, {16'd0, 16'd0, 16'd8, 16'd0},
          1'b1, '{44'd0, 1'b1, 3'd2, 10'd7}},
        '{3'd3, TRI_SIZES, {16'hFFFF, 16'd1023, 16'd1, 16'd1},
          1'b0, '0},
        '{3'd3, TRI_SIZES, {16'd0, 16'd1024, 16'd0, 16'd0},
          1'b1, '{44'd0, 1'b1, 3'd3, 10'd1023}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [IDX_W-1:0]      i_index_dim0 = '0;
    logic [IDX_W-1:0]      i_index_dim1 = '0;
    logic [IDX_W-1:0]      i_index_dim2 = '0;
    logic [IDX_W-1:0]      i_index_dim3 = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [OFF_W-1:0]      o_byte_offset;
    logic                  o_out_of_bounds;
    logic [BAD_W-1:0]      o_bad_dimension;
    logic [SIZE_W-1:0]     o_highest_allowed;

    // Local copy of the configuration registers.
    logic [CNT_W-1:0] dim_count_reg = RESET_DIM_COUNT;
    size_set_t        dim_size_reg = {DEFAULT_DIM_SIZE, DEFAULT_DIM_SIZE,
                                      DEFAULT_DIM_SIZE, AUTO_DIM_SIZE};

    access_t queued_accesses [$];
    t_result expected_offsets [$];

    logic    quiet_run = 1'b0;
    logic    hold_req = 1'b0;
    logic    hold_done = 1'b0;
    int      hold_left = 0;
    int      idle_cycles = 0;
    int      mismatch_count = 0;
    int      checked_count = 0;
    int      oob_count = 0;
    int      shape_count = 0;
    t_result seen;
    t_result want;

    multidim_array_offset_top #(
        .MAX_DIMS          (MAX_DIMS),
        .ELEM_BYTES        (ELEM_BYTES),
        .HEADER_WORD_BYTES (HEADER_WORD_BYTES)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_index_dim0      (i_index_dim0),
        .i_index_dim1      (i_index_dim1),
        .i_index_dim2      (i_index_dim2),
        .i_index_dim3      (i_index_dim3),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_byte_offset     (o_byte_offset),
        .o_out_of_bounds   (o_out_of_bounds),
        .o_bad_dimension   (o_bad_dimension),
        .o_highest_allowed (o_highest_allowed)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Computes the byte offset of one access under the current shape, or the
    // first failing dimension when an index is at or above its extent.
    function automatic t_result element_offset(input idx_word_t idx);
        int         n;
        logic       failed;
        logic [63:0] ext;
        logic [63:0] sum;
        logic [63:0] stride;
        logic [63:0] total;
        t_result    r;
        n = int'(dim_count_reg);
        if (n < 1) n = 1;
        if (n > MAX_DIMS) n = MAX_DIMS;
        if (n > NUM_LANES) n = NUM_LANES;
        failed = 1'b0;
        sum = '0;
        stride = 64'd1;
        r = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (!failed && i < n) begin
                ext = 64'(dim_size_reg[i]) + 64'd1;
                if (64'(idx[i]) >= ext) begin
                    failed = 1'b1;
                    r.out_of_bounds = 1'b1;
                    r.bad_dimension = BAD_W'(i + 1);
                    r.highest_allowed = dim_size_reg[i];
                end else begin
                    sum = sum + stride * 64'(idx[i]);
                    stride = stride * ext;
                end
            end
        end
        if (!failed) begin
            total = 64'(n) * 64'(HEADER_WORD_BYTES) + 64'(ELEM_BYTES) * sum;
            r.byte_offset = total[OFF_W-1:0];
        end
        return r;
    endfunction

    // Mirrors a register write into the local copy; spare indexes are dropped.
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DIM_COUNT: begin
                dim_count_reg = data[CNT_W-1:0];
            end
            CFG_SIZE_DIM0, CFG_SIZE_DIM1, CFG_SIZE_DIM2, CFG_SIZE_DIM3: begin
                dim_size_reg[idx - CFG_SIZE_DIM0] = data[SIZE_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Writes one register and waits for the handshake. Valid is left high so
    // that back-to-back writes keep it asserted.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    // Loads a whole array shape. The upper data bits of the count word are
    // random since the register keeps only its low bits.
    task automatic configure(input logic [CNT_W-1:0] dims, input size_set_t sizes,
                             input logic spare);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[CNT_W-1:0] = dims;
        write_reg(CFG_DIM_COUNT, data);
        for (int i = 0; i < NUM_LANES; i++) begin
            write_reg(CFG_IDX_W'(int'(CFG_SIZE_DIM0) + i), CFG_DATA_W'(sizes[i]));
        end
        if (spare) begin
            write_reg(CFG_IDX_W'($urandom_range(LAST_SPARE_REG, FIRST_SPARE_REG)),
                      CFG_DATA_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
        shape_count++;
    endtask

    // Waits until every queued access has been sent and answered.
    task automatic drain();
        while (queued_accesses.size() != 0 || expected_offsets.size() != 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    // Index word sender: holds a stalled word, otherwise offers the next one
    // unless it idles this cycle.
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            expected_offsets.push_back(queued_accesses[0].res);
            void'(queued_accesses.pop_front());
        end
        if (!i_in_valid || !o_in_stall) begin
            if (queued_accesses.size() != 0
                && (quiet_run || $urandom_range(99, 0) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_index_dim0 <= queued_accesses[0].idx[0];
                i_index_dim1 <= queued_accesses[0].idx[1];
                i_index_dim2 <= queued_accesses[0].idx[2];
                i_index_dim3 <= queued_accesses[0].idx[3];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result word receiver: checks each accepted word against the oldest
    // expected offset, then decides the stall for the next cycle.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            seen = '{o_byte_offset, o_out_of_bounds, o_bad_dimension, o_highest_allowed};
            if (expected_offsets.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result word: offset %0h oob %0b dim %0d max %0d",
                             seen.byte_offset, seen.out_of_bounds, seen.bad_dimension,
                             seen.highest_allowed);
            end else begin
                want = expected_offsets.pop_front();
                checked_count++;
                if (want.out_of_bounds) oob_count++;
                if (seen.byte_offset !== want.byte_offset
                    || seen.out_of_bounds !== want.out_of_bounds
                    || seen.bad_dimension !== want.bad_dimension
                    || seen.highest_allowed !== want.highest_allowed) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"Mismatch at word %0d: offset %0h oob %0b dim %0d max %0d,",
                                  " expected offset %0h oob %0b dim %0d max %0d"},
                                 checked_count, seen.byte_offset, seen.out_of_bounds,
                                 seen.bad_dimension, seen.highest_allowed,
                                 want.byte_offset, want.out_of_bounds,
                                 want.bad_dimension, want.highest_allowed);
                end
            end
        end
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet_run && ($urandom_range(99, 0) < IDLE_PCT);
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random shapes, then wind down.
    initial begin
        logic [CNT_W-1:0] dims;
        size_set_t        sizes;
        access_t          acc;
        int               roll;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; the shape changes only once the pipeline is empty.
        for (int r = 0; r < NUM_PROBES; r++) begin
            if (probe_rows[r].dims != dim_count_reg || probe_rows[r].sizes != dim_size_reg) begin
                drain();
                configure(probe_rows[r].dims, probe_rows[r].sizes, 1'b0);
            end
            acc.idx = probe_rows[r].idx;
            acc.res = probe_rows[r].known ? probe_rows[r].res : element_offset(acc.idx);
            queued_accesses.push_back(acc);
        end

        // Random shapes, mostly small so that in-bounds accesses are common.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            roll = $urandom_range(99, 0);
            dims = (roll < 80) ? CNT_W'($urandom_range(4, 1)) : CNT_W'($urandom);
            for (int i = 0; i < NUM_LANES; i++) begin
                roll = $urandom_range(99, 0);
                if (roll < 70) sizes[i] = SIZE_W'($urandom_range(12, 0));
                else if (roll < 85) sizes[i] = SIZE_W'($urandom);
                else if (roll < 93) sizes[i] = '1;
                else sizes[i] = '0;
            end
            configure(dims, sizes, 1'b1);
            quiet_run = (p == QUIET_PHASE);
            if (p == HOLD_PHASE) hold_req = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    roll = $urandom_range(99, 0);
                    if (roll < 80)
                        acc.idx[i] = IDX_W'($urandom_range(int'(dim_size_reg[i]), 0));
                    else if (roll < 88) acc.idx[i] = IDX_W'(dim_size_reg[i]);
                    else if (roll < 94) acc.idx[i] = IDX_W'(dim_size_reg[i]) + 1'b1;
                    else acc.idx[i] = IDX_W'($urandom);
                end
                acc.res = element_offset(acc.idx);
                queued_accesses.push_back(acc);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d result words under %0d array shapes, %0d of them out of bounds.",
                 checked_count, shape_count, oob_count);
        $display("Shapes ranged from size-zero to full-size dimensions with counts 0 to 7.");
        if (mismatch_count == 0 && expected_offsets.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
